>>> design/cqef_pkg.sv
`timescale 1ns / 1ps

package cqef_pkg;

   localparam int DEPTH     = 16;
   localparam int ITEM_BITS = 32;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int FILL_BITS = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_EXTRACT = 2'd2,
      OP_FIND    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STATUS_DONE      = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_RANGE     = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_POP,
      ST_EXT_ITEM,
      ST_SHIFT,
      ST_FIND
   } state_type;

   typedef struct packed {
      op_type                 command;
      logic [ITEM_BITS-1:0]   value;
      logic [ADDR_BITS-1:0]   position;
   } req_word_type;

   typedef struct packed {
      status_type             status;
      logic [ITEM_BITS-1:0]   item_out;
      logic [ADDR_BITS-1:0]   found_at;
      logic [FILL_BITS-1:0]   fill_level;
   } rsp_word_type;

   typedef struct packed {
      logic       latch;
      logic       rd_en;
      logic       k_clr;
      logic       k_pos;
      logic       k_inc;
      logic       wr_push;
      logic       wr_shift;
      logic       pop_done;
      logic       ext_done;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_use_rd;
      logic       rsp_found;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   pos_bad;
      logic   more;
      logic   match;
   } dp_stat_type;

endpackage

>>> design/cqef_ram.sv
`timescale 1ns / 1ps

module cqef_ram #(
   parameter int WORD_BITS = 32,
   parameter int WORDS     = 16
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(WORDS)-1:0]  wr_addr,
   input  logic [WORD_BITS-1:0]      wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(WORDS)-1:0]  rd_addr,
   output logic [WORD_BITS-1:0]      rd_data
);

   logic [WORD_BITS-1:0] mem_ff [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/cqef_ctrl.sv
`timescale 1ns / 1ps

module cqef_ctrl import cqef_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_status = STATUS_DONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            unique case (stat.op)
               OP_PUSH: begin
                  cmd.rsp_load = 1'b1;
                  if (stat.full) begin
                     cmd.rsp_status = STATUS_FULL;
                  end else begin
                     cmd.wr_push = 1'b1;
                  end
                  state_in = ST_IDLE;
               end
               OP_POP: begin
                  if (stat.empty) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_EMPTY;
                     state_in       = ST_IDLE;
                  end else begin
                     cmd.k_clr = 1'b1;
                     cmd.rd_en = 1'b1;
                     state_in  = ST_POP;
                  end
               end
               OP_EXTRACT: begin
                  if (stat.pos_bad) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_RANGE;
                     state_in       = ST_IDLE;
                  end else begin
                     cmd.k_pos = 1'b1;
                     cmd.rd_en = 1'b1;
                     state_in  = ST_EXT_ITEM;
                  end
               end
               OP_FIND: begin
                  if (stat.empty) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_NOT_FOUND;
                     state_in       = ST_IDLE;
                  end else begin
                     cmd.k_clr = 1'b1;
                     cmd.rd_en = 1'b1;
                     state_in  = ST_FIND;
                  end
               end
            endcase
         end
         ST_POP: begin
            cmd.pop_done   = 1'b1;
            cmd.rsp_load   = 1'b1;
            cmd.rsp_use_rd = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_EXT_ITEM: begin
            if (stat.more) begin
               // keep the removed word until the shift ends
               cmd.rsp_use_rd = 1'b1;
               cmd.k_inc      = 1'b1;
               cmd.rd_en      = 1'b1;
               state_in       = ST_SHIFT;
            end else begin
               cmd.ext_done   = 1'b1;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_use_rd = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            cmd.wr_shift = 1'b1;
            if (stat.more) begin
               cmd.k_inc = 1'b1;
               cmd.rd_en = 1'b1;
            end else begin
               cmd.ext_done = 1'b1;
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FIND: begin
            if (stat.match) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_found = 1'b1;
               state_in      = ST_IDLE;
            end else if (stat.more) begin
               cmd.k_inc = 1'b1;
               cmd.rd_en = 1'b1;
            end else begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STATUS_NOT_FOUND;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> design/cqef_dp.sv
`timescale 1ns / 1ps

module cqef_dp import cqef_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   logic [ADDR_BITS-1:0] head_ff, head_in;
   logic [ADDR_BITS-1:0] tail_ff, tail_in;
   logic [FILL_BITS-1:0] occ_ff, occ_in;
   logic [ADDR_BITS-1:0] k_ff, k_in;
   op_type               op_ff;
   logic [ITEM_BITS-1:0] value_ff;
   logic [ADDR_BITS-1:0] pos_ff;
   logic [ITEM_BITS-1:0] item_ff, item_in;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_ff, rsp_in;

   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [ITEM_BITS-1:0] wr_data;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [ITEM_BITS-1:0] rd_data;

   // queue pointers and fill
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      priority if (cmd.wr_push) begin
         tail_in = tail_ff + ADDR_BITS'(1);
         occ_in  = occ_ff + FILL_BITS'(1);
      end else if (cmd.pop_done) begin
         head_in = head_ff + ADDR_BITS'(1);
         occ_in  = occ_ff - FILL_BITS'(1);
      end else if (cmd.ext_done) begin
         tail_in = tail_ff - ADDR_BITS'(1);
         occ_in  = occ_ff - FILL_BITS'(1);
      end else begin
         occ_in = occ_ff;
      end
   end

   always_comb begin
      priority if (cmd.k_clr) begin
         k_in = '0;
      end else if (cmd.k_pos) begin
         k_in = pos_ff;
      end else if (cmd.k_inc) begin
         k_in = k_ff + ADDR_BITS'(1);
      end else begin
         k_in = k_ff;
      end
   end

   always_comb begin
      item_in = cmd.latch ? '0 : item_ff;
      rsp_in            = rsp_ff;
      rsp_in.status     = cmd.rsp_status;
      rsp_in.item_out   = cmd.rsp_use_rd ? rd_data : item_ff;
      rsp_in.found_at   = cmd.rsp_found ? k_ff : '0;
      rsp_in.fill_level = occ_in;
      if (cmd.rsp_use_rd) begin
         item_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      item_ff <= item_in;
      if (cmd.latch) begin
         op_ff    <= req_word.command;
         value_ff <= req_word.value;
         pos_ff   <= req_word.position;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // shift writes slot k-1 with the word read at slot k
   assign wr_en   = cmd.wr_push | cmd.wr_shift;
   assign wr_addr = cmd.wr_push ? tail_ff : (head_ff + k_ff - ADDR_BITS'(1));
   assign wr_data = cmd.wr_push ? value_ff : rd_data;
   assign rd_addr = head_ff + k_in;

   cqef_ram #(
      .WORD_BITS (ITEM_BITS),
      .WORDS     (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.op      = op_ff;
   assign stat.full    = (occ_ff == FILL_BITS'(DEPTH));
   assign stat.empty   = (occ_ff == '0);
   assign stat.pos_bad = (FILL_BITS'(pos_ff) >= occ_ff);
   assign stat.more    = ((FILL_BITS'(k_ff) + FILL_BITS'(1)) < occ_ff);
   assign stat.match   = (rd_data == value_ff);

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

endmodule

>>> design/circular_queue_extract_find.sv
`timescale 1ns / 1ps

// channel   ports                        handshake
// request   req_word                     taken when start && !busy
// response  rsp_word                     rsp_strobe high one cycle, no backpressure
//
// One word is handled at a time; the response strobe shows in the first cycle busy is low.
// Push and refused commands end in decide; pop reads the head slot, find compares entries
// in turn, extract shifts the rest down; the slot RAM reads and writes one entry a cycle.
// Reset (synchronous) empties the queue; slot contents are not cleared.
// The receiver cannot stall; a response is lost if not taken in its cycle.

module circular_queue_extract_find import cqef_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   cqef_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   cqef_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted word");

   a_rsp_on_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("no response when command finished");

   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back to back responses");

   a_full_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == STATUS_FULL) |->
         (rsp_word.fill_level == FILL_BITS'(DEPTH)))
      else $error("full reported below capacity");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.fill_level <= FILL_BITS'(DEPTH)))
      else $error("fill level beyond capacity");

endmodule
